// ===== rtl/adsr_pkg.sv =====
`timescale 1ns / 1ps
// Package: shared types, widths and constants of the ADSR envelope generator.
package adsr_pkg;

    // Time and level formats
    localparam int TIME_BITS       = 32;
    localparam int LEVEL_FRAC_BITS = 15;
    localparam int TIME_W          = TIME_BITS;
    localparam int DUR_W           = 20;
    localparam int LEVEL_W         = 16;
    localparam int CFG_DATA_W      = 20;
    localparam int CFG_IDX_W       = 3;

    // Quotient keeps one bit above any level so a large release step saturates cleanly
    localparam int QUO_W      = LEVEL_W + 1;
    localparam int PROD_W     = TIME_W + LEVEL_W;
    localparam int CNT_W      = $clog2(QUO_W);
    localparam int CMP_W      = (TIME_W > DUR_W + 1) ? TIME_W : DUR_W + 1;
    localparam int AMP_CALC_W = (LEVEL_FRAC_BITS + 2 > QUO_W + 1) ? LEVEL_FRAC_BITS + 2
                                                                  : QUO_W + 1;
    localparam int AMP_MAX     = 1 << LEVEL_FRAC_BITS;
    localparam int FLOOR_LEVEL = AMP_MAX / 10000;

    // Register reset values
    localparam logic [DUR_W-1:0]   ATTACK_RST  = DUR_W'(4410);
    localparam logic [DUR_W-1:0]   DECAY_RST   = DUR_W'(441);
    localparam logic [DUR_W-1:0]   RELEASE_RST = DUR_W'(8820);
    localparam logic [LEVEL_W-1:0] START_RST   = LEVEL_W'(32768);
    localparam logic [LEVEL_W-1:0] SUSTAIN_RST = LEVEL_W'(26214);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTACK  = 3'd0,
        CFG_DECAY   = 3'd1,
        CFG_RELEASE = 3'd2,
        CFG_START   = 3'd3,
        CFG_SUSTAIN = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ACT_QUERY    = 2'd0,
        ACT_NOTE_ON  = 2'd1,
        ACT_NOTE_OFF = 2'd2,
        ACT_RESERVED = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STG_RELEASE = 2'd0,
        STG_ATTACK  = 2'd1,
        STG_DECAY   = 2'd2,
        STG_SUSTAIN = 2'd3
    } stage_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ELAP,
        ST_SEL,
        ST_MUL,
        ST_CHK,
        ST_DIV,
        ST_FIN
    } seq_state_t;

    typedef struct packed {
        action_t           action;
        logic [TIME_W-1:0] time_req;
    } in_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] amplitude;
        stage_t             stage;
    } out_t;

endpackage

// ===== rtl/adsr_envelope_generator.sv =====
`timescale 1ns / 1ps
// Top level: linear ADSR envelope generator with a sequenced multiply and divide.
//
// Each input transfer carries an action (query, note on, note off) and a time in
// samples; the block updates its held flag and trigger times, then returns one
// transfer with the envelope amplitude (unsigned Q1.15) and the stage at that time.
// Ramp points are elapsed * span / duration: one 32x16 multiply, a saturation
// check, then a 17-step restoring divider that yields one quotient bit a cycle.
// That divider sets the rate: an item needing a ramp point runs the multiply,
// the check and every divider step, a saturated release point skips the divider,
// and a sustain point or an attack query before its trigger skips both. The input
// stalls until the item is done. The result sits in an output register, so
// the next item is taken while a result still waits on out_stall; the sequencer
// holds in its final step only if the previous result is still not taken.
// Configuration is a plain write port and must be used only while the block is
// idle. A duration of zero acts as one. Amplitudes at or below 3 come out as 0,
// and anything above 1.0 is clipped to 1.0.
module adsr_envelope_generator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [adsr_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  adsr_pkg::in_t                        in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output adsr_pkg::out_t                       out_data
);
    import adsr_pkg::*;

    // Configuration registers
    logic [DUR_W-1:0]   attack_reg;
    logic [DUR_W-1:0]   decay_reg;
    logic [DUR_W-1:0]   release_reg;
    logic [LEVEL_W-1:0] start_reg;
    logic [LEVEL_W-1:0] sustain_reg;

    // Note state
    logic              held_reg,  held_next;
    logic [TIME_W-1:0] on_reg,    on_next;
    logic [TIME_W-1:0] off_reg,   off_next;

    // Sequencer
    seq_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Datapath
    logic [TIME_W-1:0]  mag_reg,   mag_next;   // raw difference, then magnitude
    logic               neg_reg,   neg_next;
    logic               up_reg,    up_next;    // decay rises towards sustain
    stage_t             stage_reg, stage_next;
    logic [TIME_W-1:0]  x_reg,     x_next;
    logic [LEVEL_W-1:0] lev_reg,   lev_next;
    logic [DUR_W-1:0]   div_reg,   div_next;
    logic [PROD_W-1:0]  rem_reg,   rem_next;
    logic [PROD_W-1:0]  dsh_reg,   dsh_next;
    logic [QUO_W-1:0]   q_reg,     q_next;

    // Output register
    logic out_valid_reg, out_valid_next;
    out_t out_data_reg,  out_data_next;

    logic               in_acc;
    logic               load_out;
    logic [DUR_W-1:0]   att, dec, rel;
    logic [CMP_W-1:0]   mag_w, att_w, att_dec_w;
    logic               ge;
    logic               sat;
    logic [AMP_CALC_W-1:0] amp_raw, amp_fin;
    logic [AMP_CALC_W-1:0] q_ext, start_ext, sus_ext;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign load_out  = (state_reg == ST_FIN) && !(out_valid_reg && out_stall);

    // Zero duration reads as one
    assign att = (attack_reg  == '0) ? DUR_W'(1) : attack_reg;
    assign dec = (decay_reg   == '0) ? DUR_W'(1) : decay_reg;
    assign rel = (release_reg == '0) ? DUR_W'(1) : release_reg;

    assign mag_w     = CMP_W'(mag_reg);
    assign att_w     = CMP_W'(att);
    assign att_dec_w = CMP_W'(att) + CMP_W'(dec);

    // Shared compare-subtract of the divider
    assign ge  = (rem_reg >= dsh_reg);
    assign sat = (rem_reg >= PROD_W'({div_reg, {QUO_W{1'b0}}}));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_acc) state_next = ST_ELAP;
            ST_ELAP: state_next = ST_SEL;
            ST_SEL:
            begin
                if (held_reg && (neg_reg || mag_w <= att_w))
                    state_next = neg_reg ? ST_FIN : ST_MUL;
                else if (held_reg && mag_w > att_dec_w)
                    state_next = ST_FIN;
                else
                    state_next = ST_MUL;
            end
            ST_MUL:  state_next = ST_CHK;
            ST_CHK:  state_next = sat ? ST_FIN : ST_DIV;
            ST_DIV:  if (cnt_reg == '0) state_next = ST_FIN;
            ST_FIN:  if (load_out) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and note state
    always_comb
    begin
        held_next  = held_reg;
        on_next    = on_reg;
        off_next   = off_reg;
        cnt_next   = cnt_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        up_next    = up_reg;
        stage_next = stage_reg;
        x_next     = x_reg;
        lev_next   = lev_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        q_next     = q_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (in_data.action)
                        ACT_NOTE_ON:
                        begin
                            held_next = 1'b1;
                            on_next   = in_data.time_req;
                            mag_next  = '0;
                        end
                        ACT_NOTE_OFF:
                        begin
                            held_next = 1'b0;
                            off_next  = in_data.time_req;
                            mag_next  = '0;
                        end
                        ACT_QUERY, ACT_RESERVED:
                            mag_next = in_data.time_req - (held_reg ? on_reg : off_reg);
                    endcase
                end
            end
            ST_ELAP:
            begin
                neg_next = mag_reg[TIME_W-1];
                mag_next = mag_reg[TIME_W-1] ? (~mag_reg + TIME_W'(1)) : mag_reg;
            end
            ST_SEL:
            begin
                up_next = (sustain_reg >= start_reg);
                if (held_reg && (neg_reg || mag_w <= att_w))
                begin
                    stage_next = STG_ATTACK;
                    x_next     = mag_reg;
                    lev_next   = start_reg;
                    div_next   = att;
                end
                else if (held_reg && mag_w <= att_dec_w)
                begin
                    stage_next = STG_DECAY;
                    x_next     = TIME_W'(mag_w - att_w);
                    lev_next   = (sustain_reg >= start_reg) ? sustain_reg - start_reg
                                                            : start_reg - sustain_reg;
                    div_next   = dec;
                end
                else if (held_reg)
                begin
                    stage_next = STG_SUSTAIN;
                end
                else
                begin
                    stage_next = STG_RELEASE;
                    x_next     = mag_reg;
                    lev_next   = sustain_reg;
                    div_next   = rel;
                end
            end
            ST_MUL:
            begin
                rem_next = PROD_W'(x_reg) * PROD_W'(lev_reg);
            end
            ST_CHK:
            begin
                dsh_next = PROD_W'({div_reg, {(QUO_W-1){1'b0}}});
                cnt_next = CNT_W'(QUO_W - 1);
                if (sat)
                    q_next = '1;
            end
            ST_DIV:
            begin
                if (ge)
                    rem_next = rem_reg - dsh_reg;
                dsh_next = dsh_reg >> 1;
                q_next   = {q_reg[QUO_W-2:0], ge};
                cnt_next = cnt_reg - CNT_W'(1);
            end
            ST_FIN: ;
            default: ;
        endcase
    end

    // Result assembly, clamp and output register
    assign q_ext     = AMP_CALC_W'(q_reg);
    assign start_ext = AMP_CALC_W'(start_reg);
    assign sus_ext   = AMP_CALC_W'(sustain_reg);

    always_comb
    begin
        unique case (stage_reg)
            STG_ATTACK:  amp_raw = neg_reg ? '0 : q_ext;
            STG_DECAY:   amp_raw = up_reg ? start_ext + q_ext : start_ext - q_ext;
            STG_SUSTAIN: amp_raw = sus_ext;
            STG_RELEASE:
            begin
                if (neg_reg)
                    amp_raw = sus_ext + q_ext;
                else if (q_ext < sus_ext)
                    amp_raw = sus_ext - q_ext;
                else
                    amp_raw = '0;
            end
        endcase

        priority if (amp_raw <= AMP_CALC_W'(FLOOR_LEVEL))
            amp_fin = '0;
        else if (amp_raw > AMP_CALC_W'(AMP_MAX))
            amp_fin = AMP_CALC_W'(AMP_MAX);
        else
            amp_fin = amp_raw;

        out_data_next = out_data_reg;
        if (load_out)
        begin
            out_data_next.amplitude = amp_fin[LEVEL_W-1:0];
            out_data_next.stage     = stage_reg;
        end

        if (load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control, note state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            held_reg      <= 1'b0;
            on_reg        <= '0;
            off_reg       <= '0;
            attack_reg    <= ATTACK_RST;
            decay_reg     <= DECAY_RST;
            release_reg   <= RELEASE_RST;
            start_reg     <= START_RST;
            sustain_reg   <= SUSTAIN_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            held_reg      <= held_next;
            on_reg        <= on_next;
            off_reg       <= off_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ATTACK:  attack_reg  <= cfg_data[DUR_W-1:0];
                    CFG_DECAY:   decay_reg   <= cfg_data[DUR_W-1:0];
                    CFG_RELEASE: release_reg <= cfg_data[DUR_W-1:0];
                    CFG_START:   start_reg   <= cfg_data[LEVEL_W-1:0];
                    CFG_SUSTAIN: sustain_reg <= cfg_data[LEVEL_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath payload
    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        up_reg       <= up_next;
        stage_reg    <= stage_next;
        x_reg        <= x_next;
        lev_reg      <= lev_next;
        div_reg      <= div_next;
        rem_reg      <= rem_next;
        dsh_reg      <= dsh_next;
        q_reg        <= q_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ===== rtl/adsr_chk.sv =====
`timescale 1ns / 1ps
// Checker: port-level assertions on the ADSR envelope generator, bound to the top level.
module adsr_chk (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_stall,
    input  adsr_pkg::in_t  in_data,
    input  logic           out_valid,
    input  logic           out_stall,
    input  adsr_pkg::out_t out_data
);
    import adsr_pkg::*;

    // One item at a time: the input stalls right after a transfer
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after transfer");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");

    // Amplitude never above 1.0
    a_amp_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.amplitude <= LEVEL_W'(AMP_MAX)))
        else $error("amplitude above full scale");

    // Levels at or below the floor are forced to zero
    a_amp_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.amplitude == '0 ||
                       out_data.amplitude > LEVEL_W'(FLOOR_LEVEL)))
        else $error("amplitude inside the floor band");

endmodule

bind adsr_envelope_generator adsr_chk u_adsr_chk (.*);

// ===== test/adsr_envelope_generator_test.sv =====
`timescale 1ns / 1ps
// Testbench: directed and random checks of the linear ADSR envelope generator.
//
// Items go in through a send task that holds valid until the transfer is taken.
// One clocked process watches both channels. On an output transfer it pops the
// oldest expected envelope point and compares it field by field. On an input
// transfer it runs the local envelope model and queues the point it predicts.
// The output is popped before the input is pushed, because a result and a new
// item can share one clock edge. The model keeps its own copy of the gate flag,
// both trigger stamps and the five registers. Registers are only rewritten once
// the queue of expected points is empty and the block has had time to settle.
module adsr_envelope_generator_test;
    import adsr_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 30;   // a little over the longest item

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    in_t                   in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_t                  out_data;

    // Local copy of the envelope registers and state
    logic [DUR_W-1:0]   attack_len = ATTACK_RST;
    logic [DUR_W-1:0]   decay_len = DECAY_RST;
    logic [DUR_W-1:0]   release_len = RELEASE_RST;
    logic [LEVEL_W-1:0] peak_level = START_RST;
    logic [LEVEL_W-1:0] hold_level = SUSTAIN_RST;
    logic               gate = 1'b0;
    logic [TIME_W-1:0]  on_stamp = '0;
    logic [TIME_W-1:0]  off_stamp = '0;

    out_t pending_points[$];
    int   mismatches = 0;
    int   cycle_count = 0;
    int   in_idle_pct = 0;
    int   out_stall_pct = 0;

    adsr_envelope_generator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #6 clk = ~clk;

    // Guard against a hung handshake
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver back-pressure, redrawn every cycle
    always @(posedge clk)
    begin
        out_stall <= (out_stall_pct != 0) && ($urandom_range(99) < out_stall_pct);
    end

    // A duration of zero behaves as one
    function automatic logic [63:0] effective_len(logic [DUR_W-1:0] n);
        return (n == '0) ? 64'd1 : {44'd0, n};
    endfunction

    // Envelope point after applying the item's action to the local state
    function automatic out_t envelope_at(in_t item);
        logic [63:0]       att;
        logic [63:0]       dec;
        logic [63:0]       rel;
        logic [63:0]       mag;
        logic [63:0]       span;
        logic [63:0]       moved;
        logic [63:0]       level;
        logic [63:0]       peak;
        logic [63:0]       hold;
        logic [TIME_W-1:0] diff;
        logic [TIME_W-1:0] diff_mag;
        logic              behind;
        logic              live;
        stage_t            phase;
        out_t              point;

        att = effective_len(attack_len);
        dec = effective_len(decay_len);
        rel = effective_len(release_len);
        peak = {48'd0, peak_level};
        hold = {48'd0, hold_level};

        if (item.action == ACT_NOTE_ON)
        begin
            on_stamp = item.time_req;
            gate = 1'b1;
        end
        else if (item.action == ACT_NOTE_OFF)
        begin
            off_stamp = item.time_req;
            gate = 1'b0;
        end

        // signed elapsed time since the relevant trigger, as sign and magnitude
        diff = item.time_req - (gate ? on_stamp : off_stamp);
        behind = diff[TIME_W-1];
        diff_mag = behind ? (~diff + 1'b1) : diff;
        mag = {32'd0, diff_mag};
        live = 1'b0;
        level = '0;

        if (gate)
        begin
            if (behind || mag <= att)
            begin
                // before the trigger the level is negative and so silent
                phase = STG_ATTACK;
                if (!behind)
                begin
                    level = mag * peak / att;
                    live = 1'b1;
                end
            end
            else if (mag <= att + dec)
            begin
                phase = STG_DECAY;
                span = (hold >= peak) ? hold - peak : peak - hold;
                moved = (mag - att) * span / dec;
                level = (hold >= peak) ? peak + moved : peak - moved;
                live = 1'b1;
            end
            else
            begin
                phase = STG_SUSTAIN;
                level = hold;
                live = 1'b1;
            end
        end
        else
        begin
            phase = STG_RELEASE;
            moved = mag * hold / rel;
            if (behind)
            begin
                // ramp extended backwards climbs above the sustain level
                level = hold + moved;
                live = 1'b1;
            end
            else if (moved < hold)
            begin
                level = hold - moved;
                live = 1'b1;
            end
        end

        if (!live || level <= FLOOR_LEVEL)
            level = '0;
        if (level > AMP_MAX)
            level = 64'(AMP_MAX);

        point.amplitude = level[LEVEL_W-1:0];
        point.stage = phase;
        return point;
    endfunction

    // Scoreboard: results first, then new items, on every edge
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_points.size() == 0)
                begin
                    $error("result with nothing expected: amplitude %0d, stage %0d",
                           out_data.amplitude, out_data.stage);
                    mismatches++;
                end
                else
                begin
                    want = pending_points.pop_front();
                    if (out_data.amplitude !== want.amplitude)
                    begin
                        $error("amplitude: expected %0d, got %0d",
                               want.amplitude, out_data.amplitude);
                        mismatches++;
                    end
                    if (out_data.stage !== want.stage)
                    begin
                        $error("stage: expected %0d, got %0d", want.stage, out_data.stage);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
                pending_points.push_back(envelope_at(in_data));
        end
    end

    // One input transfer. Valid stays high on return; the caller either sends
    // again in the same step or lowers it through wait_idle.
    task automatic send_item(action_t act, logic [TIME_W-1:0] stamp);
        in_t item;
        item.action = act;
        item.time_req = stamp;
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Drop valid, let every expected point come back, then let the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic set_envelope(logic [DUR_W-1:0] att, logic [DUR_W-1:0] dec,
                                logic [DUR_W-1:0] rel, logic [LEVEL_W-1:0] peak,
                                logic [LEVEL_W-1:0] hold);
        write_reg(CFG_ATTACK, att);
        write_reg(CFG_DECAY, dec);
        write_reg(CFG_RELEASE, rel);
        write_reg(CFG_START, CFG_DATA_W'(peak));
        write_reg(CFG_SUSTAIN, CFG_DATA_W'(hold));
        cfg_we <= 1'b0;
        attack_len = att;
        decay_len = dec;
        release_len = rel;
        peak_level = peak;
        hold_level = hold;
    endtask

    function automatic logic [DUR_W-1:0] pick_duration();
        case ($urandom_range(9))
            0: return '0;
            1: return DUR_W'(1);
            2: return '1;
            3, 4, 5: return DUR_W'($urandom_range(64, 2));
            default: return DUR_W'($urandom_range(20'hFFFFF, 1));
        endcase
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_level();
        case ($urandom_range(7))
            0: return '0;
            1: return LEVEL_W'(AMP_MAX);
            2: return LEVEL_W'($urandom_range(FLOOR_LEVEL + 1, FLOOR_LEVEL));
            default: return LEVEL_W'($urandom_range(AMP_MAX));
        endcase
    endfunction

    // Offset into a ramp: mostly inside it or just past it, with the edges and a little before
    function automatic logic [TIME_W-1:0] ramp_offset(logic [TIME_W-1:0] span);
        case ($urandom_range(7))
            0: return -TIME_W'($urandom_range(16, 1));
            1: return '0;
            2: return span;
            3: return span + 1'b1;
            default: return $urandom_range(span + span / 4 + 1);
        endcase
    endfunction

    function automatic action_t query_kind();
        return ($urandom_range(7) == 0) ? ACT_RESERVED : ACT_QUERY;
    endfunction

    // Mostly whole notes (on, queries, off, queries) at random times, some noise
    task automatic random_notes(int items);
        logic [TIME_W-1:0] base;
        logic [TIME_W-1:0] off_at;
        logic [TIME_W-1:0] rise;
        int sent;
        int held_queries;
        int tail_queries;
        sent = 0;
        set_envelope(pick_duration(), pick_duration(), pick_duration(),
                     pick_level(), pick_level());
        while (sent < items)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_item(action_t'($urandom_range(3)), $urandom);
                sent++;
            end
            else
            begin
                base = $urandom;
                rise = TIME_W'(effective_len(attack_len) + effective_len(decay_len));
                held_queries = $urandom_range(4, 1);
                tail_queries = $urandom_range(4, 1);
                send_item(ACT_NOTE_ON, base);
                repeat (held_queries)
                    send_item(query_kind(), base + ramp_offset(rise));
                off_at = base + ramp_offset(rise + rise / 2);
                send_item(ACT_NOTE_OFF, off_at);
                repeat (tail_queries)
                    send_item(query_kind(), off_at +
                              ramp_offset(TIME_W'(effective_len(release_len))));
                sent += 2 + held_queries + tail_queries;
            end
        end
        wait_idle();
    endtask

    // Reset values: release from time zero, then one full note
    task automatic test_reset_defaults();
        in_idle_pct = 0;
        out_stall_pct = 0;
        send_item(ACT_QUERY, 32'd0);
        send_item(ACT_RESERVED, 32'd4410);
        send_item(ACT_QUERY, 32'd8820);
        send_item(ACT_QUERY, 32'hFFFF_FFFF);       // just before the off trigger
        send_item(ACT_QUERY, 32'h8000_0000);       // most negative elapsed time
        send_item(ACT_QUERY, 32'h7FFF_FFFF);
        send_item(ACT_NOTE_ON, 32'd1000);
        send_item(ACT_QUERY, 32'd999);             // before the on trigger
        send_item(ACT_QUERY, 32'd3205);
        send_item(ACT_QUERY, 32'd5410);            // top of attack
        send_item(ACT_QUERY, 32'd5851);            // end of decay
        send_item(ACT_QUERY, 32'd5852);
        send_item(ACT_NOTE_ON, 32'hFFFF_FFF0);     // retrigger across the wrap
        send_item(ACT_QUERY, 32'h0000_0100);
        send_item(ACT_NOTE_OFF, 32'h0000_2000);
        send_item(ACT_QUERY, 32'h0000_1FFF);
        send_item(ACT_QUERY, 32'h0000_2000 + 32'd8820);
        wait_idle();
    endtask

    // Zero durations act as one; longest ramps; rising and falling decay
    task automatic test_extreme_settings();
        set_envelope('0, '0, '0, '0, LEVEL_W'(AMP_MAX));
        send_item(ACT_NOTE_ON, 32'hFFFF_FFFF);
        send_item(ACT_QUERY, 32'd0);
        send_item(ACT_QUERY, 32'd1);
        send_item(ACT_QUERY, 32'd2);
        send_item(ACT_NOTE_OFF, 32'd5);
        send_item(ACT_QUERY, 32'd6);
        wait_idle();
        set_envelope('1, '1, '1, LEVEL_W'(AMP_MAX), '0);
        send_item(ACT_NOTE_ON, 32'h8000_0000);
        send_item(ACT_QUERY, 32'h8000_0000 + 32'hF_FFFF);
        send_item(ACT_QUERY, 32'h8000_0000 + 32'h1F_FFFE);
        wait_idle();
    endtask

    task automatic test_random_steady();
        in_idle_pct = 0;
        out_stall_pct = 0;
        random_notes(58);
        random_notes(58);
    endtask

    task automatic test_random_sender_gaps();
        in_idle_pct = 70;
        out_stall_pct = 0;
        random_notes(58);
        random_notes(58);
    endtask

    task automatic test_random_receiver_stalls();
        in_idle_pct = 0;
        out_stall_pct = 70;
        random_notes(58);
        random_notes(58);
    endtask

    task automatic test_random_both_sides();
        in_idle_pct = 38;
        out_stall_pct = 38;
        random_notes(58);
        random_notes(58);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_extreme_settings();
        test_random_steady();
        test_random_sender_gaps();
        test_random_receiver_stalls();
        test_random_both_sides();

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/adsr_pkg.sv
rtl/adsr_envelope_generator.sv
rtl/adsr_chk.sv
test/adsr_envelope_generator_test.sv
